@@ rtl/zpct_pkg.sv @@
// zpct_pkg: shared types, constants and helper functions of the z-order thinning unit.
// Used by the Morton encoder, the sort cell and the top level. No dependencies.
`timescale 1ns / 1ps

package zpct_pkg;

    // Default store capacity
    localparam int MAX_POINTS_DEF = 64;

    // Quantization grid
    localparam int GRID_BITS = 10;
    localparam int GRID_MAX  = (1 << GRID_BITS) - 1;
    localparam int CODE_W    = 3 * GRID_BITS;

    // Reset value of the thinning radius
    localparam logic [13:0] RADIUS_RESET = 14'd328;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } point_t;

    typedef struct packed {
        point_t            pt;
        logic [CODE_W-1:0] code;
    } entry_t;

    // Broadcast control for the cell chain
    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctl_t;

    // floor((raw + 1.0) * GRID_MAX / 2) in Q2.14, clamped to 0..GRID_MAX
    function automatic logic [GRID_BITS-1:0] quantize(input logic signed [15:0] raw);
        logic signed [17:0]   t;
        logic [27:0]          prod;
        logic [12:0]          q;
        logic [GRID_BITS-1:0] res;
        t    = 18'(raw) + 18'sd16384;
        prod = 28'(t[16:0]) * 28'(GRID_MAX);
        q    = prod[27:15];
        if (t < 0)
            res = '0;
        else if (q > 13'(GRID_MAX))
            res = GRID_BITS'(GRID_MAX);
        else
            res = q[GRID_BITS-1:0];
        return res;
    endfunction

    // Squared difference of two coordinates; always fits 32 bits unsigned
    function automatic logic [31:0] sq_diff(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
        logic signed [16:0] d;
        logic signed [33:0] p;
        d = 17'(a) - 17'(b);
        p = 34'(d) * 34'(d);
        return p[31:0];
    endfunction

endpackage

@@ rtl/zorder_point_cloud_thinning_unit.sv @@
// zorder_point_cloud_thinning_unit: takes one point per cycle into the sorted cell chain.
// Emission takes each stored point through a squares state, then a sum-and-compare state,
// and ends with a flush state. Output stalls hold emission; input waits until it ends.
// Reset clears point count, overflow flag, state and output valid; radius returns to 328.
// Depends on zpct_pkg, zpct_morton, zpct_cell.
`timescale 1ns / 1ps

module zorder_point_cloud_thinning_unit #(
    parameter int MAX_POINTS = zpct_pkg::MAX_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [13:0]                   cfg_radius,
    // input points
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [15:0]            point_x,
    input  logic signed [15:0]            point_y,
    input  logic signed [15:0]            point_z,
    input  logic                          final_point,
    // kept points
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [15:0]            kept_x,
    output logic signed [15:0]            kept_y,
    output logic signed [15:0]            kept_z,
    output logic [zpct_pkg::CODE_W-1:0]   morton_code,
    output logic                          overflowed,
    output logic                          end_of_set
);
    import zpct_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [1:0] {
        S_FILL,
        S_SQ,
        S_DEC,
        S_FLUSH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [13:0]      radius_reg;
    logic [27:0]      rsq_reg;
    entry_t           pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [31:0]      sq_reg [3];
    logic [31:0]      sq_next [3];
    entry_t           out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_eos_reg, out_eos_next;
    logic             out_ovf_reg, out_ovf_next;

    cell_ctl_t              ctl;
    entry_t                 new_entry;
    logic [CODE_W-1:0]      new_code;
    entry_t                 cell_q [MAX_POINTS];
    logic [MAX_POINTS-1:0]  gt_w;
    logic [MAX_POINTS-1:0]  valid_w;
    entry_t                 head;
    logic                   in_xfer;
    logic                   full;
    logic                   slot_free;
    logic [33:0]            dist_sum;
    logic                   keep;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_FILL);
    assign in_xfer   = in_valid && in_ready;
    assign full      = (count_reg == CNT_W'(MAX_POINTS));
    assign slot_free = !out_valid_reg || out_ready;

    // Code of the incoming point
    zpct_morton u_morton (
        .point_x (point_x),
        .point_y (point_y),
        .point_z (point_z),
        .code    (new_code)
    );

    assign new_entry.pt.x = point_x;
    assign new_entry.pt.y = point_y;
    assign new_entry.pt.z = point_z;
    assign new_entry.code = new_code;

    // Sorted chain of cells
    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        assign valid_w[i] = (CNT_W'(i) < count_reg);
        if (i == 0)
        begin : g_first
            zpct_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .self_valid (valid_w[i]),
                .prev_valid (1'b1),
                .prev_gt    (1'b0),
                .new_entry  (new_entry),
                .prev_entry (new_entry),
                .next_entry (cell_q[i+1]),
                .entry      (cell_q[i]),
                .gt         (gt_w[i])
            );
        end
        else if (i == MAX_POINTS - 1)
        begin : g_last
            zpct_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .self_valid (valid_w[i]),
                .prev_valid (valid_w[i-1]),
                .prev_gt    (gt_w[i-1]),
                .new_entry  (new_entry),
                .prev_entry (cell_q[i-1]),
                .next_entry (cell_q[i]),
                .entry      (cell_q[i]),
                .gt         (gt_w[i])
            );
        end
        else
        begin : g_mid
            zpct_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .self_valid (valid_w[i]),
                .prev_valid (valid_w[i-1]),
                .prev_gt    (gt_w[i-1]),
                .new_entry  (new_entry),
                .prev_entry (cell_q[i-1]),
                .next_entry (cell_q[i+1]),
                .entry      (cell_q[i]),
                .gt         (gt_w[i])
            );
        end
    end

    assign head = cell_q[0];

    // Distance check against the last kept point
    assign dist_sum = 34'(sq_reg[0]) + 34'(sq_reg[1]) + 34'(sq_reg[2]);
    assign keep     = !pend_valid_reg || (dist_sum > 34'(rsq_reg));

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        sq_next         = sq_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        out_eos_next    = out_eos_reg;
        out_ovf_next    = out_ovf_reg;
        ctl             = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_FILL:
            begin
                if (in_xfer)
                begin
                    if (!full)
                    begin
                        ctl.insert = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (final_point)
                        state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                sq_next[0] = sq_diff(head.pt.x, pend_reg.pt.x);
                sq_next[1] = sq_diff(head.pt.y, pend_reg.pt.y);
                sq_next[2] = sq_diff(head.pt.z, pend_reg.pt.z);
                state_next = S_DEC;
            end
            S_DEC:
            begin
                // a new keeper pushes out the previous one, which needs the slot
                if (!keep || !pend_valid_reg || slot_free)
                begin
                    if (keep)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_valid_next = 1'b1;
                            out_eos_next   = 1'b0;
                            out_ovf_next   = ovf_reg;
                        end
                        pend_next       = head;
                        pend_valid_next = 1'b1;
                    end
                    ctl.drain  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    state_next = (count_reg == CNT_W'(1)) ? S_FLUSH : S_SQ;
                end
            end
            S_FLUSH:
            begin
                if (slot_free)
                begin
                    out_next        = pend_reg;
                    out_valid_next  = 1'b1;
                    out_eos_next    = 1'b1;
                    out_ovf_next    = ovf_reg;
                    pend_valid_next = 1'b0;
                    ovf_next        = 1'b0;
                    state_next      = S_FILL;
                end
            end
            default:
            begin
                state_next = S_FILL;
            end
        endcase
    end

    // State, control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_FILL;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            radius_reg     <= RADIUS_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
                radius_reg <= cfg_radius;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rsq_reg     <= 28'(radius_reg) * 28'(radius_reg);
        pend_reg    <= pend_next;
        sq_reg      <= sq_next;
        out_reg     <= out_next;
        out_eos_reg <= out_eos_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign out_valid   = out_valid_reg;
    assign kept_x      = out_reg.pt.x;
    assign kept_y      = out_reg.pt.y;
    assign kept_z      = out_reg.pt.z;
    assign morton_code = out_reg.code;
    assign overflowed  = out_ovf_reg;
    assign end_of_set  = out_eos_reg;

`ifndef SYNTHESIS
    // Fill count never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");

    // Chain head pair is in code order while draining
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEC && count_reg >= CNT_W'(2)) |-> (cell_q[0].code <= cell_q[1].code))
    else $error("cell chain out of order");

    // Flush always has a pending kept point
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |-> pend_valid_reg)
    else $error("flush without pending point");

    // Last result of a set leaves the block empty and ready for the next set
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && slot_free) |=> (count_reg == '0 && !ovf_reg && in_ready))
    else $error("set not cleared after flush");
`endif

endmodule

@@ rtl/zpct_morton.sv @@
// zpct_morton: quantizes a Q2.14 point to the grid and interleaves the axes.
// Depends on zpct_pkg (quantize, GRID_BITS, CODE_W).
`timescale 1ns / 1ps

module zpct_morton (
    input  logic signed [15:0]            point_x,
    input  logic signed [15:0]            point_y,
    input  logic signed [15:0]            point_z,
    output logic [zpct_pkg::CODE_W-1:0]   code
);
    import zpct_pkg::*;

    logic [GRID_BITS-1:0] qx;
    logic [GRID_BITS-1:0] qy;
    logic [GRID_BITS-1:0] qz;

    assign qx = quantize(point_x);
    assign qy = quantize(point_y);
    assign qz = quantize(point_z);

    // x in bit 0, y in bit 1, z in bit 2 of each triple
    always_comb
    begin
        code = '0;
        for (int b = 0; b < GRID_BITS; b++)
        begin
            code[3*b]     = qx[b];
            code[3*b + 1] = qy[b];
            code[3*b + 2] = qz[b];
        end
    end

endmodule

@@ rtl/zpct_cell.sv @@
// zpct_cell: one slot of the sorted chain; shifts up on insert, down on drain.
// Depends on zpct_pkg (entry_t, cell_ctl_t).
`timescale 1ns / 1ps

module zpct_cell (
    input  logic                 clk,
    input  zpct_pkg::cell_ctl_t  ctl,
    input  logic                 self_valid,
    input  logic                 prev_valid,
    input  logic                 prev_gt,
    input  zpct_pkg::entry_t     new_entry,
    input  zpct_pkg::entry_t     prev_entry,
    input  zpct_pkg::entry_t     next_entry,
    output zpct_pkg::entry_t     entry,
    output logic                 gt
);
    import zpct_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Strictly greater keeps equal codes in arrival order
    assign gt    = self_valid && (entry_reg.code > new_entry.code);
    assign entry = entry_reg;

    // Insert: take neighbor if it moves up, else take the new point at the split
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.insert)
        begin
            if (prev_gt)
                entry_next = prev_entry;
            else if (prev_valid && (gt || !self_valid))
                entry_next = new_entry;
        end
        else if (ctl.drain)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ tb/tb_zorder_point_cloud_thinning_unit.sv @@
// tb_zorder_point_cloud_thinning_unit: self-checking testbench of the z-order thinning unit.
// Predicts Morton codes, stable code order and radius thinning per set, and checks kept points.
// Depends on zpct_pkg and zorder_point_cloud_thinning_unit.
`timescale 1ns / 1ps

module tb_zorder_point_cloud_thinning_unit;

    import zpct_pkg::*;

    localparam int CAP         = MAX_POINTS_DEF;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;
    localparam int RADIUS_MAX  = 16383;

    typedef struct {
        point_t            pt;
        logic [CODE_W-1:0] code;
        logic              ovf;
        logic              eos;
    } kept_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [13:0]          cfg_radius;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [15:0]   point_x;
    logic signed [15:0]   point_y;
    logic signed [15:0]   point_z;
    logic                 final_point;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [15:0]   kept_x;
    logic signed [15:0]   kept_y;
    logic signed [15:0]   kept_z;
    logic [CODE_W-1:0]    morton_code;
    logic                 overflowed;
    logic                 end_of_set;

    // Predictor state: sorted point store and current radius
    point_t               sorted_pts [CAP];
    logic [CODE_W-1:0]    sorted_codes [CAP];
    int                   stored_count;
    logic                 set_dropped;
    logic [13:0]          radius_cfg;
    kept_t                pending_kept [$];

    int                   err_count = 0;
    int                   burst_left;
    bit                   idle_gaps;
    int                   rx_mode;
    int                   hold_req;
    int                   hold_seen = 0;
    int                   hold_left = 0;
    int                   stall_phase = 0;
    int                   quiet_cycles = 0;

    zorder_point_cloud_thinning_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_radius    (cfg_radius),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .final_point   (final_point),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kept_x        (kept_x),
        .kept_y        (kept_y),
        .kept_z        (kept_z),
        .morton_code   (morton_code),
        .overflowed    (overflowed),
        .end_of_set    (end_of_set)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    // Grid cell of one coordinate: floor((v + 1.0) * 1023 / 2), clamped
    function automatic logic [GRID_BITS-1:0] grid_cell(input logic signed [15:0] v);
        longint t;
        t = longint'(v) + 16384;
        if (t < 0)
            return '0;
        t = (t * GRID_MAX) / 32768;
        if (t > GRID_MAX)
            t = GRID_MAX;
        return GRID_BITS'(t);
    endfunction

    // Interleave the three grid cells, x in bit 0
    function automatic logic [CODE_W-1:0] morton_of(input point_t p);
        logic [GRID_BITS-1:0] qx, qy, qz;
        logic [CODE_W-1:0]    c;
        qx = grid_cell(p.x);
        qy = grid_cell(p.y);
        qz = grid_cell(p.z);
        for (int i = 0; i < GRID_BITS; i++)
        begin
            c[3*i]     = qx[i];
            c[3*i + 1] = qy[i];
            c[3*i + 2] = qz[i];
        end
        return c;
    endfunction

    function automatic longint dist2(input point_t a, input point_t b);
        longint dx, dy, dz;
        dx = longint'(a.x) - longint'(b.x);
        dy = longint'(a.y) - longint'(b.y);
        dz = longint'(a.z) - longint'(b.z);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    // Insert one accepted point; on the final point, thin the sorted set
    function automatic void store_point(input point_t p, input logic fin);
        logic [CODE_W-1:0] c;
        int                pos;
        longint            rsq;
        point_t            anchor;
        kept_t             k;
        kept_t             batch [$];
        if (stored_count < CAP)
        begin
            c   = morton_of(p);
            pos = stored_count;
            // equal codes stay behind earlier arrivals
            while (pos > 0 && sorted_codes[pos - 1] > c)
            begin
                sorted_codes[pos] = sorted_codes[pos - 1];
                sorted_pts[pos]   = sorted_pts[pos - 1];
                pos--;
            end
            sorted_codes[pos] = c;
            sorted_pts[pos]   = p;
            stored_count++;
        end
        else
            set_dropped = 1'b1;
        if (!fin)
            return;
        rsq = longint'(radius_cfg) * longint'(radius_cfg);
        for (int i = 0; i < stored_count; i++)
        begin
            if (i == 0 || dist2(sorted_pts[i], anchor) > rsq)
            begin
                anchor = sorted_pts[i];
                k.pt   = sorted_pts[i];
                k.code = sorted_codes[i];
                k.ovf  = set_dropped;
                k.eos  = 1'b0;
                batch.insert(batch.size(), k);
            end
        end
        batch[batch.size() - 1].eos = 1'b1;
        foreach (batch[j])
            pending_kept.insert(pending_kept.size(), batch[j]);
        stored_count = 0;
        set_dropped  = 1'b0;
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin : kept_checker
        kept_t exp_k;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_kept.size() == 0)
            begin
                $display("%0t: unexpected kept point, expected none, actual x=%0d y=%0d z=%0d",
                         $time, kept_x, kept_y, kept_z);
                err_count++;
            end
            else
            begin
                exp_k = pending_kept.pop_front();
                check_field("kept_x", longint'(exp_k.pt.x), longint'(kept_x));
                check_field("kept_y", longint'(exp_k.pt.y), longint'(kept_y));
                check_field("kept_z", longint'(exp_k.pt.z), longint'(kept_z));
                check_field("morton_code", longint'(exp_k.code), longint'(morton_code));
                check_field("overflowed", longint'(exp_k.ovf), longint'(overflowed));
                check_field("end_of_set", longint'(exp_k.eos), longint'(end_of_set));
            end
        end
    end

    // ---------------------------------------------------------------
    // Output pacing: free, random or fixed stall pattern, plus long holds
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin : rx_pacing
        logic r;
        if (hold_left > 0)
        begin
            r = 1'b0;
            hold_left--;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES - 1;
            r         = 1'b0;
        end
        else
        begin
            case (rx_mode)
                0:       r = 1'b1;
                1:       r = ($urandom_range(0, 3) != 0);
                default: r = ((stall_phase % 9) < 5);
            endcase
        end
        stall_phase++;
        out_ready <= r;
    end

    // Watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic point_t mk_point(input int x, input int y, input int z);
        point_t p;
        p.x = 16'(x);
        p.y = 16'(y);
        p.z = 16'(z);
        return p;
    endfunction

    function automatic logic signed [15:0] clip16(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // One point transfer, with burst/gap pacing on the input side
    task automatic send_point(input point_t p, input logic fin);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (idle_gaps)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        point_x     <= p.x;
        point_y     <= p.y;
        point_z     <= p.z;
        final_point <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        store_point(p, fin);
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Wait until every kept point has arrived and emission has wound down
    task automatic settle_idle();
        release_input();
        while (pending_kept.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_radius(input logic [13:0] r);
        @(negedge clk);
        cfg_valid  <= 1'b1;
        cfg_radius <= r;
        do
            @(posedge clk);
        while (!cfg_ready);
        radius_cfg = r;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A set of n points: full-range noise or a cluster sized to the radius
    task automatic send_set(input int n);
        point_t center, p, prev;
        int     spread;
        bit     clustered;
        clustered = ($urandom_range(0, 3) != 0);
        spread    = int'(radius_cfg) * 2 + 4;
        if (spread > 20000)
            spread = 20000;
        center.x = 16'($urandom);
        center.y = 16'($urandom);
        center.z = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && $urandom_range(0, 7) == 0)
                p = prev;
            else if (clustered)
            begin
                p.x = clip16(int'(center.x) + int'($urandom_range(0, 2 * spread)) - spread);
                p.y = clip16(int'(center.y) + int'($urandom_range(0, 2 * spread)) - spread);
                p.z = clip16(int'(center.z) + int'($urandom_range(0, 2 * spread)) - spread);
            end
            else
            begin
                p.x = 16'($urandom);
                p.y = 16'($urandom);
                p.z = 16'($urandom);
            end
            send_point(p, (i == n - 1));
            prev = p;
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Grid boundaries, clamping, per-axis interleave, equal codes; reset radius
    task automatic test_grid_extremes();
        send_point(mk_point(-32768, -32768, -32768), 1'b0);
        send_point(mk_point(32767, 32767, 32767), 1'b0);
        send_point(mk_point(0, 0, 0), 1'b0);
        send_point(mk_point(10, 0, 0), 1'b0);
        send_point(mk_point(-16384, -16384, -16384), 1'b0);
        send_point(mk_point(-16383, 0, 16383), 1'b0);
        send_point(mk_point(16384, 16384, 16384), 1'b0);
        send_point(mk_point(16383, -16385, 16385), 1'b0);
        send_point(mk_point(32767, -32768, -32768), 1'b0);
        send_point(mk_point(-32768, 32767, -32768), 1'b0);
        send_point(mk_point(-32768, -32768, 32767), 1'b1);
        settle_idle();
    endtask

    task automatic test_single_point();
        send_point(mk_point(1234, -4321, 77), 1'b1);
        settle_idle();
    endtask

    // Radius 0: exact duplicates are dropped, any other point is kept
    task automatic test_zero_radius();
        write_radius(14'd0);
        send_point(mk_point(100, 100, 100), 1'b0);
        send_point(mk_point(100, 100, 100), 1'b0);
        send_point(mk_point(101, 100, 100), 1'b0);
        send_point(mk_point(-5, 7, -9), 1'b0);
        send_point(mk_point(-5, 7, -9), 1'b1);
        settle_idle();
    endtask

    // Largest radius; a point exactly at the radius is dropped
    task automatic test_full_radius();
        write_radius(14'(RADIUS_MAX));
        send_point(mk_point(0, 0, 0), 1'b0);
        send_point(mk_point(16383, 0, 0), 1'b0);
        send_point(mk_point(16384, 0, 0), 1'b0);
        send_point(mk_point(-20000, 5, -3), 1'b0);
        send_point(mk_point(32767, 32767, -32768), 1'b1);
        settle_idle();
    endtask

    // Full store: final point dropped, then excess points before the final one
    task automatic test_capacity_overflow();
        write_radius(14'd200);
        idle_gaps = 1'b0;
        rx_mode   = 0;
        send_set(CAP + 1);
        idle_gaps = 1'b1;
        rx_mode   = 1;
        send_set(CAP + 6);
        send_set(3);
        settle_idle();
    endtask

    // Long output hold while the next set keeps coming
    task automatic test_output_backpressure();
        write_radius(14'd1000);
        idle_gaps = 1'b0;
        hold_req++;
        send_set(20);
        send_set(20);
        settle_idle();
    endtask

    task automatic test_random_sets();
        int sent, n;
        logic [13:0] r;
        sent = 0;
        while (sent < 170)
        begin
            case ($urandom_range(0, 5))
                0:       r = 14'd0;
                1:       r = 14'(RADIUS_MAX);
                2:       r = 14'($urandom_range(1, 64));
                3:       r = 14'($urandom_range(100, 2000));
                default: r = 14'($urandom);
            endcase
            write_radius(r);
            idle_gaps = ($urandom_range(0, 2) != 0);
            rx_mode   = $urandom_range(0, 2);
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(30, CAP);
                else
                    n = $urandom_range(1, 16);
                send_set(n);
                sent += n;
            end
            settle_idle();
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_radius    = '0;
        in_valid      = 1'b0;
        point_x       = '0;
        point_y       = '0;
        point_z       = '0;
        final_point   = 1'b0;
        stored_count  = 0;
        set_dropped   = 1'b0;
        radius_cfg    = RADIUS_RESET;
        burst_left    = 0;
        idle_gaps     = 1'b1;
        rx_mode       = 1;
        hold_req      = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_grid_extremes();
        test_single_point();
        test_zero_radius();
        test_full_radius();
        test_capacity_overflow();
        test_output_backpressure();
        test_random_sets();

        while (pending_kept.size() != 0)
            @(posedge clk);
        repeat (SETTLE * 4) @(posedge clk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
